[hdl/sgs_pkg.sv]
// Shared types and constants for the Savitzky-Golay smoother.
package sgs_pkg;

  // Sample width and saturation limits
  localparam int SMP_W   = 16;
  localparam int SMP_MAX = 32767;
  localparam int SMP_MIN = -32768;

  // Row and column indexes cover the largest supported window (31)
  localparam int IDX_W = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             shift;     // take the accepted sample into the window
    logic             issue;     // one multiply-accumulate term this cycle
    logic [IDX_W-1:0] row;       // weight table row of the current result
    logic [IDX_W-1:0] col;       // window column of the current term
    logic             run_last;  // current result closes the request's run
    logic             load_err;  // load the frame-too-short result
  } sgs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_busy;  // output register holds a result not yet taken
    logic row_done;  // a dot product lands in the output register now
  } sgs_stat_t;

endpackage

[hdl/sgs_ctrl.sv]
// Sequencer: frame fill tracking, row scheduling and term issue.
module sgs_ctrl #(
  parameter int WINDOW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tlast,
  input  sgs_pkg::sgs_stat_t stat,
  output sgs_pkg::sgs_cmd_t  cmd
);

  localparam int FW     = $clog2(WINDOW + 1);
  localparam int IW     = $clog2(WINDOW);
  localparam int HALF_W = (WINDOW - 1) / 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_WAIT,
    ST_ROW_RUN,
    ST_ROW_DRAIN,
    ST_ERR_WAIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] row_r, row_nxt;
  logic [IW-1:0] row_end_r, row_end_nxt;
  logic [IW-1:0] col_r, col_nxt;
  logic          accept;
  logic          full_now;
  logic          first_fill;

  assign accept     = in_tvalid && (state_r == ST_IDLE);
  assign full_now   = fill_r >= FW'(WINDOW - 1);
  assign first_fill = fill_r == FW'(WINDOW - 1);

  // Next state and counters
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    row_nxt     = row_r;
    row_end_nxt = row_end_r;
    col_nxt     = col_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tlast) begin
            fill_nxt = '0;
          end else if (fill_r < FW'(WINDOW)) begin
            fill_nxt = fill_r + FW'(1);
          end
          if (full_now) begin
            row_nxt     = first_fill ? '0 : IW'(HALF_W);
            row_end_nxt = in_tlast ? IW'(WINDOW - 1) : IW'(HALF_W);
            state_nxt   = ST_ROW_WAIT;
          end else if (in_tlast) begin
            state_nxt = ST_ERR_WAIT;
          end
        end
      end
      ST_ROW_WAIT: begin
        if (!stat.out_busy) begin
          col_nxt   = '0;
          state_nxt = ST_ROW_RUN;
        end
      end
      ST_ROW_RUN: begin
        if (col_r == IW'(WINDOW - 1)) begin
          state_nxt = ST_ROW_DRAIN;
        end else begin
          col_nxt = col_r + IW'(1);
        end
      end
      ST_ROW_DRAIN: begin
        if (stat.row_done) begin
          if (row_r == row_end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = row_r + IW'(1);
            state_nxt = ST_ROW_WAIT;
          end
        end
      end
      ST_ERR_WAIT: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      row_r     <= '0;
      row_end_r <= '0;
      col_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      row_r     <= row_nxt;
      row_end_r <= row_end_nxt;
      col_r     <= col_nxt;
    end
  end

  // Drive commands
  assign in_tready    = (state_r == ST_IDLE);
  assign cmd.shift    = accept;
  assign cmd.issue    = (state_r == ST_ROW_RUN);
  assign cmd.row      = sgs_pkg::IDX_W'(row_r);
  assign cmd.col      = sgs_pkg::IDX_W'(col_r);
  assign cmd.run_last = (row_r == row_end_r);
  assign cmd.load_err = (state_r == ST_ERR_WAIT) && !stat.out_busy;

endmodule

[hdl/sgs_datapath.sv]
// Datapath: sample window, weight ROM, MAC pipeline and output register.
module sgs_datapath #(
  parameter int WINDOW         = 7,
  parameter int POLY_ORDER     = 2,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sgs_pkg::sgs_cmd_t          cmd,
  output sgs_pkg::sgs_stat_t         stat,
  input  logic [sgs_pkg::SMP_W-1:0]  in_sample,
  output logic [sgs_pkg::SMP_W-1:0]  out_smoothed,
  output logic                       out_run_last,
  output logic                       out_too_short,
  output logic                       out_valid,
  input  logic                       out_ready
);

  localparam int IW     = $clog2(WINDOW);
  localparam int HALF_W = (WINDOW - 1) / 2;
  localparam int CW     = COEF_FRAC_BITS + 2;
  localparam int PW     = sgs_pkg::SMP_W + CW;
  localparam int ACC_W  = PW + $clog2(WINDOW) + 1;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(sgs_pkg::SMP_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(sgs_pkg::SMP_MIN);
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  // ---- Elaboration-time weight table ----

  // Restoring division, one quotient bit per step
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Truncating signed division by a positive value
  function automatic longint sdiv(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned quo;
    mag = (num < 0) ? longint'(-num) : num;
    quo = udiv(mag, den);
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // Integer square root, two bits per step
  function automatic longint unsigned isqrt(input longint unsigned val);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bitv;
    v    = val;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Recurrence weight beta_k in Q56, long division 8 bits per step
  function automatic longint unsigned beta_q56(input longint unsigned k);
    longint unsigned w;
    longint unsigned num;
    longint unsigned den;
    longint unsigned val;
    longint unsigned rem;
    longint unsigned q;
    w   = longint'(WINDOW);
    num = k * k * (w * w - k * k);
    den = 4 * (4 * k * k - 1);
    val = udiv(num, den);
    rem = num - val * den;
    for (int i = 0; i < 7; i++) begin
      rem = rem << 8;
      q   = udiv(rem, den);
      val = (val << 8) | q;
      rem = rem - q * den;
    end
    return val;
  endfunction

  function automatic longint clampq(input longint v);
    longint lim;
    lim = longint'(1) << 29;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One weight: sum over orthonormal polynomials at offsets r and c
  function automatic longint coef_entry(input int r, input int c);
    longint          lim;
    longint          acc;
    longint          pr, pc, cr, cc, nr, nc;
    longint          sp, sn;
    longint          xr, xc;
    longint unsigned mag;
    int              sh;
    lim = longint'(1) << COEF_FRAC_BITS;
    if (POLY_ORDER >= WINDOW - 1) return (r == c) ? lim : 0;
    acc = 0;
    pr  = 0;
    pc  = 0;
    cr  = longint'(isqrt(udiv(64'd1 << 56, longint'(WINDOW))));
    cc  = cr;
    sp  = 0;
    xr  = longint'(r - HALF_W);
    xc  = longint'(c - HALF_W);
    for (int k = 0; k <= POLY_ORDER; k++) begin
      acc = acc + cr * cc;
      if (k < POLY_ORDER) begin
        sn = longint'(isqrt(beta_q56(longint'(k + 1))));
        if (sn < 1) sn = 1;
        nr = clampq(sdiv(xr * cr * (longint'(1) << 28) - sp * pr, sn));
        nc = clampq(sdiv(xc * cc * (longint'(1) << 28) - sp * pc, sn));
        pr = cr;
        pc = cc;
        cr = nr;
        cc = nc;
        sp = sn;
      end
    end
    sh  = 56 - COEF_FRAC_BITS;
    mag = (acc < 0) ? longint'(-acc) : acc;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (mag > longint'(lim)) mag = lim;
    return (acc < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  logic signed [CW-1:0] coef_rom [WINDOW][WINDOW];

  for (genvar gr = 0; gr < WINDOW; gr++) begin : g_row
    for (genvar gc = 0; gc < WINDOW; gc++) begin : g_col
      assign coef_rom[gr][gc] = CW'(coef_entry(gr, gc));
    end
  end

  // ---- Sample window ----

  logic signed [sgs_pkg::SMP_W-1:0] win_r [WINDOW];

  // Shift the window by one on each accepted request, newest at the top
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < WINDOW - 1; i++) win_r[i] <= win_r[i + 1];
      win_r[WINDOW - 1] <= in_sample;
    end
  end

  // ---- MAC pipeline ----

  logic [IW-1:0]                    row_i;
  logic [IW-1:0]                    col_i;
  logic signed [CW-1:0]             coef_a_r;
  logic signed [sgs_pkg::SMP_W-1:0] samp_a_r;
  logic                             va_r, fa_r, la_r;
  logic signed [PW-1:0]             prod_b_r;
  logic                             vb_r, fb_r, lb_r;
  logic signed [ACC_W-1:0]          acc_r;
  logic                             vc_r, lc_r;

  assign row_i = cmd.row[IW-1:0];
  assign col_i = cmd.col[IW-1:0];

  // Fetch weight and sample
  always_ff @(posedge clk) begin
    coef_a_r <= coef_rom[row_i][col_i];
    samp_a_r <= win_r[col_i];
    fa_r     <= (col_i == '0);
    la_r     <= (col_i == IW'(WINDOW - 1));
  end

  // Multiply
  always_ff @(posedge clk) begin
    prod_b_r <= coef_a_r * samp_a_r;
    fb_r     <= fa_r;
    lb_r     <= la_r;
  end

  // Accumulate, restart on the first term of a row
  always_ff @(posedge clk) begin
    if (vb_r) begin
      acc_r <= fb_r ? ACC_W'(prod_b_r) : acc_r + ACC_W'(prod_b_r);
    end
    lc_r <= lb_r;
  end

  // Advance term valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // ---- Round, saturate and output register ----

  logic signed [ACC_W-1:0]          rnd_sum;
  logic signed [ACC_W-1:0]          rnd_val;
  logic signed [sgs_pkg::SMP_W-1:0] sat_val;
  logic                             row_done;
  logic                             out_valid_r;
  logic [sgs_pkg::SMP_W-1:0]        out_smoothed_r;
  logic                             out_run_last_r;
  logic                             out_too_short_r;

  assign row_done = vc_r && lc_r;
  assign rnd_sum  = acc_r + RND;
  assign rnd_val  = rnd_sum >>> COEF_FRAC_BITS;

  always_comb begin
    if (rnd_val > SAT_HI) begin
      sat_val = sgs_pkg::SMP_W'(sgs_pkg::SMP_MAX);
    end else if (rnd_val < SAT_LO) begin
      sat_val = sgs_pkg::SMP_W'(sgs_pkg::SMP_MIN);
    end else begin
      sat_val = rnd_val[sgs_pkg::SMP_W-1:0];
    end
  end

  // Load a finished result or the error result
  always_ff @(posedge clk) begin
    if (row_done) begin
      out_smoothed_r  <= sat_val;
      out_run_last_r  <= cmd.run_last;
      out_too_short_r <= 1'b0;
    end else if (cmd.load_err) begin
      out_smoothed_r  <= '0;
      out_run_last_r  <= 1'b1;
      out_too_short_r <= 1'b1;
    end
  end

  // Hold output valid until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_done || cmd.load_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_smoothed  = out_smoothed_r;
  assign out_run_last  = out_run_last_r;
  assign out_too_short = out_too_short_r;
  assign stat.out_busy = out_valid_r;
  assign stat.row_done = row_done;

endmodule

[hdl/savitzky_golay_smoother.sv]
// Top level of the Savitzky-Golay smoother: controller plus datapath.
//
// Input stream: one signed 16-bit sample per request on in_tdata, in_tlast
// marking the last sample of a frame. Output stream: smoothed samples on
// out_tdata, out_tlast on the last result caused by one input request,
// out_tuser high on the single result of a frame shorter than WINDOW.
// A frame of n >= WINDOW samples yields n results in sample order: the
// WINDOW-th sample releases the leading edge rows and the centre row, each
// later sample one centre row, and the last sample also the trailing rows.
// Each smoothed result is one dot product over WINDOW terms by a single
// multiply-accumulate unit with fetch, multiply and accumulate stages; the
// next dot product starts only once the last reaches the output register,
// so a request's results, and the (WINDOW - 1) / 2 extra ones at a frame
// edge, come one after another. A sample that releases no result leaves
// in_tready high. The weights are a ROM built at elaboration. in_tready
// is high only while the controller is idle, not computing or waiting to
// load a result; a stalled receiver holds the output register and, through
// it, the start of the next dot product. Reset empties the pipeline and
// output register and starts a new frame; the window needs no clearing.
module savitzky_golay_smoother #(
  parameter int WINDOW         = 7,
  parameter int POLY_ORDER     = 2,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] smoothed
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // [0] too_short
);

  sgs_pkg::sgs_cmd_t  cmd;
  sgs_pkg::sgs_stat_t stat;

  sgs_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  sgs_datapath #(
    .WINDOW         (WINDOW),
    .POLY_ORDER     (POLY_ORDER),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_sample     (in_tdata),
    .out_smoothed  (out_tdata),
    .out_run_last  (out_tlast),
    .out_too_short (out_tuser),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready)
  );

endmodule

[hdl/sgs_checker.sv]
// Port-level checks for the smoother, bound to the top level.
module sgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // The short-frame result is alone in its run and carries zero
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 16'd0))
    else $error("short-frame result malformed");

  // A frame end always releases a result, so input stalls next cycle
  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("frame end did not start result work");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind savitzky_golay_smoother sgs_checker u_sgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
